// ===== src/gst_pkg.sv =====
// Shared types, constants and helpers of the generational slot table.
package gst_pkg;

  localparam int SLOTS    = 16;
  localparam int SlotIdxW = $clog2(SLOTS);
  localparam int CountW   = $clog2(SLOTS + 1);
  localparam int GenW     = 32;
  localparam int KeyW     = 32;
  localparam int RevW     = 32;
  localparam int HSlotW   = 8;
  localparam int LiveW    = 9;

  typedef enum logic [1:0] {
    CmdSync    = 2'd0,
    CmdResolve = 2'd1,
    CmdRetire  = 2'd2,
    CmdReclaim = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatRefused = 2'd1,
    StatFull    = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [KeyW-1:0]   object_key;
    logic [RevW-1:0]   object_revision;
    logic              view_valid;
    logic              topology_sealed;
    logic [HSlotW-1:0] handle_slot;
    logic [GenW-1:0]   handle_generation;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [HSlotW-1:0] slot;
    logic [GenW-1:0]   generation;
    logic [LiveW-1:0]  live_count;
  } out_t;

  // One slot's stored entry.
  typedef struct packed {
    logic [GenW-1:0] gen;
    logic [KeyW-1:0] key;
    logic [RevW-1:0] rev;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Advance a generation, skipping zero on wrap.
  function automatic logic [GenW-1:0] next_gen(input logic [GenW-1:0] g);
    logic [GenW-1:0] n;
    n = g + GenW'(1);
    return (n == '0) ? GenW'(1) : n;
  endfunction

endpackage

// ===== src/gst_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/gst_result_reg.sv =====
// Output register that holds one result until the receiver takes it.
module gst_result_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gst_pkg::out_t push_data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gst_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  gst_pkg::out_t data_q;

  // Room when empty or when the held result transfers this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/generational_slot_table.sv =====
// Top level of the generational slot table: command sequencer and memories.
//
// Usage: one command transfers on the input channel (in_valid_i high, in_stall_o
// low); exactly one result transfers later on the output channel (out_valid_o
// high, out_stall_i low). Commands are handled one at a time, in order.
// Steps per command:
//   resolve / retire   : one entry read, one check, one emit; a handle slot
//                        past the created slots is refused without a read
//   synchronise        : unless the view is invalid, the key scan reads one entry
//                        per cycle from the entry RAM; popping a freed slot adds
//                        a stack read and a fetch
//   reclaim            : one entry rewrite per cycle over the created slots
// The next command is taken the cycle after its result moves to the output
// register. The scan and the reclaim walk both go through the single read
// port of the entry RAM.
// A finished result sits in an output register; the next command is taken
// while it waits. If the receiver stalls and that register is still full,
// the sequencer holds its result and stops taking commands.
// Reset clears occupancy bits and counters at once; entry and free-stack RAMs
// need no clearing pass, since an entry is read only after it was written.
module generational_slot_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  gst_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output gst_pkg::out_t out_data_o
);

  localparam int SlotIdxW = gst_pkg::SlotIdxW;
  localparam int CountW   = gst_pkg::CountW;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StScan    = 7'b0000010,
    StPop     = 7'b0000100,
    StFetch   = 7'b0001000,
    StCheck   = 7'b0010000,
    StReclaim = 7'b0100000,
    StEmit    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  gst_pkg::in_t  req_q, req_d;
  gst_pkg::out_t res_q, res_d;

  logic [CountW-1:0]   idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [SlotIdxW-1:0] pidx_q, pidx_d;
  logic [SlotIdxW-1:0] slot_q, slot_d;
  logic [gst_pkg::SLOTS-1:0] occ_q, occ_d;
  logic [CountW-1:0]   created_q, created_d;
  logic [CountW-1:0]   depth_q, depth_d;
  logic [CountW-1:0]   total_q, total_d;

  // Entry RAM ports.
  logic                e_re, e_we;
  logic [SlotIdxW-1:0] e_raddr, e_waddr;
  gst_pkg::entry_t     e_wdata, e_rdata;

  // Free-stack RAM ports.
  logic                s_re, s_we;
  logic [SlotIdxW-1:0] s_raddr, s_waddr, s_wdata, s_rdata;

  // Result register handshake.
  logic          push;
  logic          push_ready;
  gst_pkg::out_t push_data;

  logic                hit;
  logic [gst_pkg::GenW-1:0] bumped;
  logic                check_bad;

  assign in_stall_o = (state_q != StIdle);

  assign hit = pend_q && occ_q[pidx_q] && (e_rdata.key == req_q.object_key);
  assign bumped = gst_pkg::next_gen(e_rdata.gen);
  assign check_bad = (req_q.handle_generation == '0) || !occ_q[slot_q]
                     || (e_rdata.gen != req_q.handle_generation);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    slot_d    = slot_q;
    occ_d     = occ_q;
    created_d = created_q;
    depth_d   = depth_q;
    total_d   = total_q;
    e_re      = 1'b0;
    e_raddr   = idx_q[SlotIdxW-1:0];
    e_we      = 1'b0;
    e_waddr   = pidx_q;
    e_wdata   = '{gen: bumped, key: e_rdata.key, rev: e_rdata.rev};
    s_re      = 1'b0;
    s_raddr   = '0;
    s_we      = 1'b0;
    s_waddr   = pidx_q;
    s_wdata   = pidx_q;
    push      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          idx_d  = '0;
          pend_d = 1'b0;
          unique case (in_data_i.command)
            gst_pkg::CmdSync: begin
              if (!in_data_i.view_valid) begin
                res_d   = '{status: gst_pkg::StatRefused, default: '0};
                state_d = StEmit;
              end else begin
                state_d = StScan;
              end
            end
            gst_pkg::CmdResolve, gst_pkg::CmdRetire: begin
              if (gst_pkg::LiveW'(in_data_i.handle_slot) >= gst_pkg::LiveW'(created_q)) begin
                res_d = '{status: gst_pkg::StatRefused, slot: in_data_i.handle_slot,
                          default: '0};
                state_d = StEmit;
              end else begin
                // Fetch the entry; check it next cycle.
                e_re    = 1'b1;
                e_raddr = in_data_i.handle_slot[SlotIdxW-1:0];
                slot_d  = in_data_i.handle_slot[SlotIdxW-1:0];
                state_d = StCheck;
              end
            end
            gst_pkg::CmdReclaim: begin
              state_d = StReclaim;
            end
          endcase
        end
      end

      StScan: begin
        priority if (hit) begin
          priority if (e_rdata.rev == req_q.object_revision) begin
            res_d = '{status: gst_pkg::StatOk, slot: gst_pkg::HSlotW'(pidx_q),
                      generation: e_rdata.gen, default: '0};
          end else if (!req_q.topology_sealed) begin
            res_d = '{status: gst_pkg::StatRefused, default: '0};
          end else begin
            // Rebuild: store the new revision and advance the generation.
            e_we    = 1'b1;
            e_waddr = pidx_q;
            e_wdata = '{gen: bumped, key: e_rdata.key, rev: req_q.object_revision};
            res_d = '{status: gst_pkg::StatOk, slot: gst_pkg::HSlotW'(pidx_q),
                      generation: bumped, default: '0};
          end
          state_d = StEmit;
        end else if (idx_q < created_q) begin
          // Issue the next entry read; compare it next cycle.
          e_re    = 1'b1;
          e_raddr = idx_q[SlotIdxW-1:0];
          pidx_d  = idx_q[SlotIdxW-1:0];
          pend_d  = 1'b1;
          idx_d   = idx_q + CountW'(1);
        end else begin
          // Key not present: allocate if the topology is sealed and a slot is left.
          pend_d = 1'b0;
          priority if (!req_q.topology_sealed) begin
            res_d   = '{status: gst_pkg::StatRefused, default: '0};
            state_d = StEmit;
          end else if (depth_q != '0) begin
            s_re    = 1'b1;
            s_raddr = SlotIdxW'(depth_q - CountW'(1));
            state_d = StPop;
          end else if (created_q < CountW'(gst_pkg::SLOTS)) begin
            e_we    = 1'b1;
            e_waddr = created_q[SlotIdxW-1:0];
            e_wdata = '{gen: gst_pkg::GenW'(1), key: req_q.object_key,
                        rev: req_q.object_revision};
            occ_d[created_q[SlotIdxW-1:0]] = 1'b1;
            created_d = created_q + CountW'(1);
            total_d   = total_q + CountW'(1);
            res_d = '{status: gst_pkg::StatOk, slot: gst_pkg::HSlotW'(created_q),
                      generation: gst_pkg::GenW'(1), default: '0};
            state_d = StEmit;
          end else begin
            res_d   = '{status: gst_pkg::StatFull, default: '0};
            state_d = StEmit;
          end
        end
      end

      StPop: begin
        // Popped slot arrives; fetch its generation.
        slot_d  = s_rdata;
        e_re    = 1'b1;
        e_raddr = s_rdata;
        state_d = StFetch;
      end

      StFetch: begin
        // Drop the popped slot from the free stack as it turns live.
        depth_d = depth_q - CountW'(1);
        e_we    = 1'b1;
        e_waddr = slot_q;
        e_wdata = '{gen: e_rdata.gen, key: req_q.object_key, rev: req_q.object_revision};
        occ_d[slot_q] = 1'b1;
        total_d = total_q + CountW'(1);
        res_d = '{status: gst_pkg::StatOk, slot: gst_pkg::HSlotW'(slot_q),
                  generation: e_rdata.gen, default: '0};
        state_d = StEmit;
      end

      StCheck: begin
        priority if (check_bad) begin
          res_d = '{status: gst_pkg::StatRefused, slot: req_q.handle_slot,
                    generation: e_rdata.gen, default: '0};
        end else if (req_q.command == gst_pkg::CmdRetire) begin
          e_we    = 1'b1;
          e_waddr = slot_q;
          e_wdata = '{gen: bumped, key: e_rdata.key, rev: e_rdata.rev};
          occ_d[slot_q] = 1'b0;
          if (depth_q < CountW'(gst_pkg::SLOTS)) begin
            s_we    = 1'b1;
            s_waddr = depth_q[SlotIdxW-1:0];
            s_wdata = slot_q;
            depth_d = depth_q + CountW'(1);
          end
          if (total_q != '0) begin
            total_d = total_q - CountW'(1);
          end
          res_d = '{status: gst_pkg::StatOk, slot: req_q.handle_slot,
                    generation: bumped, default: '0};
        end else begin
          res_d = '{status: gst_pkg::StatOk, slot: req_q.handle_slot,
                    generation: e_rdata.gen, default: '0};
        end
        state_d = StEmit;
      end

      StReclaim: begin
        // Write back the previous entry with a bumped generation and stack it.
        if (pend_q) begin
          e_we    = 1'b1;
          e_waddr = pidx_q;
          s_we    = 1'b1;
          s_waddr = pidx_q;
          s_wdata = pidx_q;
        end
        if (idx_q < created_q) begin
          e_re    = 1'b1;
          e_raddr = idx_q[SlotIdxW-1:0];
          pidx_d  = idx_q[SlotIdxW-1:0];
          pend_d  = 1'b1;
          idx_d   = idx_q + CountW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            occ_d   = '0;
            total_d = '0;
            depth_d = created_q;
            res_d   = '{status: gst_pkg::StatOk, default: '0};
            state_d = StEmit;
          end
        end
      end

      StEmit: begin
        if (push_ready) begin
          push    = 1'b1;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Live count reflects the counters after the command has updated them.
  always_comb begin
    push_data = res_q;
    push_data.live_count = gst_pkg::LiveW'(total_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pend_q    <= 1'b0;
      idx_q     <= '0;
      occ_q     <= '0;
      created_q <= '0;
      depth_q   <= '0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      idx_q     <= idx_d;
      occ_q     <= occ_d;
      created_q <= created_d;
      depth_q   <= depth_d;
      total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    pidx_q <= pidx_d;
    slot_q <= slot_d;
  end

  gst_ram #(
    .Width(gst_pkg::EntryW),
    .Depth(gst_pkg::SLOTS)
  ) u_entry_ram (
    .clk_i    (clk_i),
    .wr_en_i  (e_we),
    .wr_addr_i(e_waddr),
    .wr_data_i(e_wdata),
    .rd_en_i  (e_re),
    .rd_addr_i(e_raddr),
    .rd_data_o(e_rdata)
  );

  gst_ram #(
    .Width(SlotIdxW),
    .Depth(gst_pkg::SLOTS)
  ) u_free_ram (
    .clk_i    (clk_i),
    .wr_en_i  (s_we),
    .wr_addr_i(s_waddr),
    .wr_data_i(s_wdata),
    .rd_en_i  (s_re),
    .rd_addr_i(s_raddr),
    .rd_data_o(s_rdata)
  );

  gst_result_reg u_result_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (push_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_total_matches_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountW'($countones(occ_q)) == total_q)
    else $error("live counter disagrees with occupancy bits");

  a_slots_accounted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gst_pkg::LiveW'(depth_q) + gst_pkg::LiveW'(total_q)) == gst_pkg::LiveW'(created_q))
    else $error("free plus live slots differ from created slots");

  a_occ_below_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q >> created_q) == '0)
    else $error("slot occupied beyond the created range");
`endif

endmodule
